/* src/assert_macros.svh */
// Assertion macros shared by the RTL. Both take the clock i_clk and the
// active-low reset i_rst_n of the instantiating module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LFU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");
`define LFU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define LFU_ASSERT(lbl, prop)
`define LFU_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* src/lfu_pkg.sv */
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int CAP_DEFAULT = 16;
    localparam int CFG_W       = 5;
    localparam int CAP_RESET   = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 31;
    localparam int USE_W       = 32;
    localparam int RD_W        = 32;

    localparam logic signed [RD_W-1:0] RD_MISS = -32'sd1;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

endpackage

/* src/lfu_if.sv */
`timescale 1ns / 1ps

interface lfu_req_if;
    import lfu_pkg::*;
    logic                    valid;
    logic                    ready;
    t_cmd                    cmd;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface lfu_rsp_if;
    import lfu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [RD_W-1:0]  read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

/* src/lfu_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module lfu_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lfu_cache_table.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// LFU key-value cache with LRU tie-break. Entries (key, value, use count,
// recency rank) live in one single-port-read RAM; valid bits are flops and
// clear at reset, so no clearing pass is needed. Each item first sweeps all
// CAPACITY entries to find its key, the eviction victim and the first free
// slot, then passes through a decision state; a hit or an insert then runs
// a read-modify-write sweep to age recency ranks, and the S_OUT state moves
// the result to the output register once it is free. One item is worked on
// at a time; the next may be taken while a result waits at the output.
module lfu_cache_table #(
    parameter int CAPACITY = lfu_pkg::CAP_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lfu_req_if.sink                    i_req,
    lfu_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]  i_cfg_wdata
);

    import lfu_pkg::*;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;
    localparam int HELD_W = $clog2(CAPACITY + 1);
    localparam int CW     = (HELD_W > CFG_W) ? HELD_W : CFG_W;
    localparam int PTR_W  = IDX_W + 1;

    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST    = IDX_W'(CAPACITY - 1);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [USE_W-1:0]  count;
        logic [RANK_W-1:0] rank;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPD,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_cap;
    logic [CAPACITY-1:0] r_valid;
    logic [HELD_W-1:0]  r_held;

    // captured item
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;

    // sweep
    logic [PTR_W-1:0]   r_ptr;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;

    // scan results
    logic               r_found;
    logic [IDX_W-1:0]   r_fidx;
    logic [RANK_W-1:0]  r_frank;
    logic [VAL_W-1:0]   r_fval;
    logic [USE_W-1:0]   r_fcount;
    logic               r_vfound;
    logic [IDX_W-1:0]   r_vidx;
    logic [USE_W-1:0]   r_vcount;
    logic [RANK_W-1:0]  r_vrank;
    logic [KEY_W-1:0]   r_vkey;
    logic               r_sfound;
    logic [IDX_W-1:0]   r_sidx;

    // update pass control
    logic [IDX_W-1:0]   r_tgt;
    t_entry             r_new;
    logic               r_inc_all;
    logic [RANK_W-1:0]  r_thresh;

    // result staging and output
    logic signed [RD_W-1:0]  r_res_rd;
    logic                    r_res_ev;
    logic [KEY_W-1:0]        r_res_evk;
    logic                    r_o_valid;
    logic                    r_o_hit;
    logic signed [RD_W-1:0]  r_o_rd;
    logic                    r_o_ev;
    logic [KEY_W-1:0]        r_o_evk;

    logic               rd_go;
    logic [ENT_W-1:0]   rdata;
    t_entry             ent;
    logic               ent_valid;
    logic               rd_last;
    logic               key_match;
    logic               better;
    logic               mem_we;
    t_entry             mem_wdata;
    logic               out_free;
    logic [CW-1:0]      cap_w;
    logic [CW-1:0]      cap_eff;
    logic [CW-1:0]      held_w;
    logic               do_evict;
    logic [IDX_W-1:0]   slot;

    assign rd_go     = (r_state == S_SCAN || r_state == S_UPD) && (r_ptr < PTR_END);
    assign ent       = t_entry'(rdata);
    assign ent_valid = r_valid[r_rd_idx];
    assign rd_last   = r_rd_vld && (r_rd_idx == LAST);
    assign key_match = ent_valid && (ent.key == r_key);
    assign better    = !r_vfound || (ent.count < r_vcount) ||
                       ((ent.count == r_vcount) && (ent.rank > r_vrank));

    assign cap_w    = CW'(r_cap);
    assign cap_eff  = (cap_w > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_w;
    assign held_w   = CW'(r_held);
    assign do_evict = (held_w >= cap_eff) && r_vfound;
    // victim slot frees up; the lowest free index wins
    assign slot     = (do_evict && !(r_sfound && (r_sidx < r_vidx))) ? r_vidx : r_sidx;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = ent;
        if (r_state == S_UPD && r_rd_vld) begin
            if (r_rd_idx == r_tgt) begin
                mem_we    = 1'b1;
                mem_wdata = r_new;
            end else if (ent_valid && (r_inc_all || (ent.rank < r_thresh))) begin
                mem_we         = 1'b1;
                mem_wdata.rank = ent.rank + RANK_W'(1);
            end
        end
    end

    assign out_free = !r_o_valid || o_rsp.ready;

    lfu_ram #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W),
        .DW    (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_rd_idx),
        .i_wdata (mem_wdata),
        .i_re    (rd_go),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CFG_W'(CAP_RESET);
            r_valid   <= '0;
            r_held    <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end

            r_rd_vld <= rd_go;
            if (rd_go) begin
                r_rd_idx <= r_ptr[IDX_W-1:0];
                r_ptr    <= r_ptr + PTR_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd    <= i_req.cmd;
                        r_key    <= i_req.key;
                        r_val    <= i_req.value;
                        r_ptr    <= '0;
                        r_found  <= 1'b0;
                        r_vfound <= 1'b0;
                        r_sfound <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_vld) begin
                        if (key_match) begin
                            r_found  <= 1'b1;
                            r_fidx   <= r_rd_idx;
                            r_frank  <= ent.rank;
                            r_fval   <= ent.value;
                            r_fcount <= ent.count;
                        end
                        if (ent_valid && better) begin
                            r_vfound <= 1'b1;
                            r_vidx   <= r_rd_idx;
                            r_vcount <= ent.count;
                            r_vrank  <= ent.rank;
                            r_vkey   <= ent.key;
                        end
                        if (!ent_valid && !r_sfound) begin
                            r_sfound <= 1'b1;
                            r_sidx   <= r_rd_idx;
                        end
                        if (rd_last) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_ptr <= '0;
                    if (r_found && (r_cmd == CMD_GET || cap_eff != '0)) begin
                        // touch: hit entry to rank 0, younger ones age
                        r_tgt       <= r_fidx;
                        r_new.key   <= r_key;
                        r_new.value <= (r_cmd == CMD_GET) ? r_fval : r_val;
                        r_new.count <= (r_fcount == '1) ? r_fcount : r_fcount + USE_W'(1);
                        r_new.rank  <= '0;
                        r_inc_all   <= 1'b0;
                        r_thresh    <= r_frank;
                        r_state     <= S_UPD;
                        r_res_rd    <= (r_cmd == CMD_GET) ? RD_W'(r_fval) : RD_MISS;
                        r_res_ev    <= 1'b0;
                        r_res_evk   <= '0;
                    end else if (!r_found && r_cmd == CMD_PUT && cap_eff != '0) begin
                        r_tgt       <= slot;
                        r_new.key   <= r_key;
                        r_new.value <= r_val;
                        r_new.count <= '0;
                        r_new.rank  <= '0;
                        r_state     <= S_UPD;
                        r_res_rd    <= RD_MISS;
                        r_valid[slot] <= 1'b1;
                        if (do_evict) begin
                            // ranks above the victim drop then rise: net unchanged
                            if (slot != r_vidx) begin
                                r_valid[r_vidx] <= 1'b0;
                            end
                            r_inc_all <= 1'b0;
                            r_thresh  <= r_vrank;
                            r_res_ev  <= 1'b1;
                            r_res_evk <= r_vkey;
                        end else begin
                            r_inc_all <= 1'b1;
                            r_thresh  <= '0;
                            r_held    <= r_held + HELD_W'(1);
                            r_res_ev  <= 1'b0;
                            r_res_evk <= '0;
                        end
                    end else begin
                        r_res_rd  <= RD_MISS;
                        r_res_ev  <= 1'b0;
                        r_res_evk <= '0;
                        r_state   <= S_OUT;
                    end
                end
                S_UPD: begin
                    if (rd_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_hit   <= r_found;
                        r_o_rd    <= r_res_rd;
                        r_o_ev    <= r_res_ev;
                        r_o_evk   <= r_res_evk;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.read_value  = r_o_rd;
    assign o_rsp.evicted     = r_o_ev;
    assign o_rsp.evicted_key = r_o_evk;

    `LFU_ASSERT(a_held_matches_valid, $countones(r_valid) == int'(r_held))
    `LFU_ASSERT(a_held_in_range, r_held <= HELD_W'(CAPACITY))
    `LFU_ASSERT_IMP(a_evict_only_on_miss, r_o_valid && r_o_ev, !r_o_hit)
    `LFU_ASSERT_IMP(a_miss_reads_minus_one, r_o_valid && !r_o_hit, r_o_rd == RD_MISS)
    `LFU_ASSERT_IMP(a_no_rw_same_entry, mem_we && rd_go, r_ptr[IDX_W-1:0] != r_rd_idx)

endmodule
